// ===== hw/rtl/csghc_pkg.sv =====
`timescale 1ns / 1ps

package csghc_pkg;

   localparam logic [1:0] REQ_LEFT  = 2'd0;
   localparam logic [1:0] REQ_RIGHT = 2'd1;
   localparam logic [1:0] REQ_END   = 2'd2;

   localparam logic [1:0] OP_UNION     = 2'd0;
   localparam logic [1:0] OP_MINUS     = 2'd1;
   localparam logic [1:0] OP_INTERSECT = 2'd2;
   localparam logic [1:0] OP_RESET     = OP_MINUS;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] hit_t;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] out_t;
      logic               from_right;
      logic               no_hit;
      logic               overflowed;
      logic               last_out;
   } rsp_item_type;

   typedef struct packed {
      logic hit_load_left;
      logic hit_load_right;
      logic start;
      logic side;
      logic cmp_v;
      logic keep_wr;
      logic scan_start;
      logic scan_v;
      logic scan_side;
      logic prev_clr;
      logic emit;
      logic list_clr;
   } cmd_type;

   typedef struct packed {
      logic emit_last;
      logic rsp_free;
   } stat_type;

endpackage

// ===== hw/rtl/csghc_dpath.sv =====
`timescale 1ns / 1ps

module csghc_dpath import csghc_pkg::*; #(
   parameter int MAX_HITS = 16,
   parameter int T_WIDTH  = 32,
   localparam int IW   = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1,
   localparam int CW   = $clog2(MAX_HITS + 1),
   localparam int KW   = $clog2(2 * MAX_HITS + 1),
   localparam int KEYW = T_WIDTH + 1 + IW
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_wdata,
   input  logic signed [31:0] hit_t,
   input  cmd_type            cmd,
   input  logic [IW-1:0]      addr_left,
   input  logic [IW-1:0]      addr_right,
   input  logic [IW-1:0]      scan_idx,
   output logic [CW-1:0]      left_cnt,
   output logic [CW-1:0]      right_cnt,
   output stat_type           stat,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_item_type       rsp_item
);

   logic [1:0]         op_mode_ff;
   logic [1:0]         mode_eff;
   logic [T_WIDTH-1:0] left_mem [MAX_HITS];
   logic [T_WIDTH-1:0] right_mem [MAX_HITS];
   logic [T_WIDTH-1:0] rd_left_ff, rd_right_ff;
   logic [T_WIDTH-1:0] hit_val;
   logic [CW-1:0]      left_cnt_ff, right_cnt_ff;
   logic               ovf_ff;
   logic               left_full, right_full;
   logic               parity_ff;
   logic [MAX_HITS-1:0] keep_left_ff, keep_right_ff;
   logic [KW-1:0]      kept_cnt_ff, out_cnt_ff;
   logic               best_valid_ff, prev_valid_ff;
   logic [KEYW-1:0]    best_key_ff, prev_key_ff;
   logic               rsp_valid_ff;
   rsp_item_type       rsp_ff;

   logic [T_WIDTH-1:0] pivot, other;
   logic               le;
   logic               keep_now;
   logic [IW-1:0]      kidx;
   logic [T_WIDTH-1:0] sval;
   logic [KEYW-1:0]    skey;
   logic               skept;
   logic               cand;
   logic [T_WIDTH-1:0] best_val;

   assign hit_val    = T_WIDTH'(hit_t);
   assign left_full  = (left_cnt_ff == CW'(MAX_HITS));
   assign right_full = (right_cnt_ff == CW'(MAX_HITS));
   assign left_cnt   = left_cnt_ff;
   assign right_cnt  = right_cnt_ff;

   always_comb begin
      case (op_mode_ff)
         OP_MINUS:     mode_eff = OP_MINUS;
         OP_INTERSECT: mode_eff = OP_INTERSECT;
         default:      mode_eff = OP_UNION;
      endcase
   end

   assign pivot = cmd.side ? rd_right_ff : rd_left_ff;
   assign other = cmd.side ? rd_left_ff : rd_right_ff;
   assign le    = ($signed(other) <= $signed(pivot));
   assign kidx  = cmd.side ? addr_right : addr_left;

   always_comb begin
      if (cmd.side) begin
         keep_now = (mode_eff == OP_UNION) ? !parity_ff : parity_ff;
      end else begin
         keep_now = (mode_eff == OP_INTERSECT) ? parity_ff : !parity_ff;
      end
   end

   assign sval  = cmd.scan_side ? rd_right_ff : rd_left_ff;
   assign skey  = {~sval[T_WIDTH-1], sval[T_WIDTH-2:0], cmd.scan_side, scan_idx};
   assign skept = cmd.scan_side ? keep_right_ff[scan_idx] : keep_left_ff[scan_idx];
   assign cand  = cmd.scan_v && skept
                  && (!prev_valid_ff || (skey > prev_key_ff))
                  && (!best_valid_ff || (skey < best_key_ff));

   assign best_val = {~best_key_ff[KEYW-1], best_key_ff[KEYW-2:IW+1]};

   assign stat.emit_last = (kept_cnt_ff == '0) || ((out_cnt_ff + KW'(1)) == kept_cnt_ff);
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.hit_load_left && !left_full) begin
         left_mem[left_cnt_ff[IW-1:0]] <= hit_val;
      end
      if (cmd.hit_load_right && !right_full) begin
         right_mem[right_cnt_ff[IW-1:0]] <= hit_val;
      end
      rd_left_ff  <= left_mem[addr_left];
      rd_right_ff <= right_mem[addr_right];
   end

   always_ff @(posedge clock) begin
      if (cmd.keep_wr) begin
         if (cmd.side) begin
            keep_right_ff[kidx] <= keep_now;
         end else begin
            keep_left_ff[kidx] <= keep_now;
         end
      end
      if (cand) begin
         best_key_ff <= skey;
      end
      if (cmd.emit) begin
         prev_key_ff <= best_key_ff;
         rsp_ff.out_t      <= best_valid_ff ? 32'($signed(best_val)) : '0;
         rsp_ff.from_right <= best_valid_ff && best_key_ff[IW];
         rsp_ff.no_hit     <= !best_valid_ff;
         rsp_ff.overflowed <= ovf_ff;
         rsp_ff.last_out   <= stat.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff    <= OP_RESET;
         left_cnt_ff   <= '0;
         right_cnt_ff  <= '0;
         ovf_ff        <= 1'b0;
         parity_ff     <= 1'b0;
         kept_cnt_ff   <= '0;
         out_cnt_ff    <= '0;
         best_valid_ff <= 1'b0;
         prev_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            op_mode_ff <= csr_wdata;
         end

         if (cmd.list_clr) begin
            left_cnt_ff  <= '0;
            right_cnt_ff <= '0;
            ovf_ff       <= 1'b0;
         end else if (cmd.hit_load_left) begin
            if (left_full) begin
               ovf_ff <= 1'b1;
            end else begin
               left_cnt_ff <= left_cnt_ff + CW'(1);
            end
         end else if (cmd.hit_load_right) begin
            if (right_full) begin
               ovf_ff <= 1'b1;
            end else begin
               right_cnt_ff <= right_cnt_ff + CW'(1);
            end
         end

         if (cmd.start || cmd.keep_wr) begin
            parity_ff <= 1'b0;
         end else if (cmd.cmp_v) begin
            parity_ff <= parity_ff ^ le;
         end

         if (cmd.start) begin
            kept_cnt_ff <= '0;
         end else if (cmd.keep_wr && keep_now) begin
            kept_cnt_ff <= kept_cnt_ff + KW'(1);
         end

         if (cmd.scan_start) begin
            best_valid_ff <= 1'b0;
         end else if (cand) begin
            best_valid_ff <= 1'b1;
         end

         if (cmd.prev_clr) begin
            prev_valid_ff <= 1'b0;
            out_cnt_ff    <= '0;
         end else if (cmd.emit) begin
            prev_valid_ff <= best_valid_ff;
            out_cnt_ff    <= out_cnt_ff + KW'(1);
         end

         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== hw/rtl/csghc_ctrl.sv =====
`timescale 1ns / 1ps

module csghc_ctrl import csghc_pkg::*; #(
   parameter int MAX_HITS = 16,
   localparam int IW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1,
   localparam int CW = $clog2(MAX_HITS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_type,
   input  logic [CW-1:0] left_cnt,
   input  logic [CW-1:0] right_cnt,
   input  stat_type      stat,
   output cmd_type       cmd,
   output logic [IW-1:0] addr_left,
   output logic [IW-1:0] addr_right,
   output logic [IW-1:0] scan_idx
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_KEEP = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type     state_ff, state_in;
   logic          side_ff, side_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic          cmp_v_ff, cmp_v_in;
   logic          sv_ff, sv_in;
   logic          sside_ff, sside_in;
   logic [IW-1:0] sidx_ff, sidx_in;
   logic [CW-1:0] n_self, n_other;

   assign n_self     = side_ff ? right_cnt : left_cnt;
   assign n_other    = side_ff ? left_cnt : right_cnt;
   assign addr_left  = side_ff ? j_ff[IW-1:0] : i_ff[IW-1:0];
   assign addr_right = side_ff ? i_ff[IW-1:0] : j_ff[IW-1:0];
   assign scan_idx   = sidx_ff;

   always_comb begin
      state_in      = state_ff;
      side_in       = side_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      cmp_v_in      = 1'b0;
      sv_in         = 1'b0;
      sside_in      = sside_ff;
      sidx_in       = sidx_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.side      = side_ff;
      cmd.cmp_v     = cmp_v_ff;
      cmd.scan_v    = sv_ff;
      cmd.scan_side = sside_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_type)
                  REQ_LEFT:  cmd.hit_load_left  = 1'b1;
                  REQ_RIGHT: cmd.hit_load_right = 1'b1;
                  REQ_END: begin
                     cmd.start = 1'b1;
                     side_in   = 1'b0;
                     i_in      = '0;
                     j_in      = '0;
                     state_in  = ST_KEEP;
                  end
                  default: ;
               endcase
            end
         end
         ST_KEEP: begin
            if (i_ff == n_self) begin
               i_in = '0;
               j_in = '0;
               if (!side_ff) begin
                  side_in = 1'b1;
               end else begin
                  side_in        = 1'b0;
                  cmd.scan_start = 1'b1;
                  cmd.prev_clr   = 1'b1;
                  state_in       = ST_SCAN;
               end
            end else if (j_ff != n_other) begin
               j_in     = j_ff + CW'(1);
               cmp_v_in = 1'b1;
            end else if (!cmp_v_ff) begin
               cmd.keep_wr = 1'b1;
               i_in        = i_ff + CW'(1);
               j_in        = '0;
            end
         end
         ST_SCAN: begin
            if (!side_ff && i_ff == left_cnt) begin
               side_in = 1'b1;
               i_in    = '0;
            end else if (side_ff && i_ff == right_cnt) begin
               if (!sv_ff) begin
                  state_in = ST_EMIT;
               end
            end else begin
               sv_in    = 1'b1;
               sside_in = side_ff;
               sidx_in  = i_ff[IW-1:0];
               i_in     = i_ff + CW'(1);
            end
         end
         ST_EMIT: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               side_in  = 1'b0;
               i_in     = '0;
               if (stat.emit_last) begin
                  cmd.list_clr = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         side_ff  <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
         cmp_v_ff <= 1'b0;
         sv_ff    <= 1'b0;
         sside_ff <= 1'b0;
         sidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         side_ff  <= side_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         cmp_v_ff <= cmp_v_in;
         sv_ff    <= sv_in;
         sside_ff <= sside_in;
         sidx_ff  <= sidx_in;
      end
   end

endmodule

// ===== hw/rtl/csg_ray_hit_combiner.sv =====
`timescale 1ns / 1ps
// CSG ray hit combiner.
// req channel: one item per cycle while idle. Left and right hit items are
// stored (up to MAX_HITS per side, extra hits set the overflow flag). An end
// item starts the combine; no item is taken until its last result is emitted.
// csr port: csr_we writes op_mode (0 union, 1 minus, 2 intersection) at once.
// Combine: the classify pass walks the other list once per stored hit, one
// compare per cycle on one read port of each hit memory. Each result item
// then takes one full walk of both lists plus an emit step. Results leave
// through an output register in ascending order, the last one flagged; an
// empty result gives one no-hit item. A stalled rsp side holds that register,
// and the next walk runs and waits for the slot to free. After the last
// result is taken into the register the block is idle again.
// Reset: lists empty, overflow clear, op_mode minus, no result pending.
module csg_ray_hit_combiner import csghc_pkg::*; #(
   parameter int MAX_HITS = 16,
   parameter int T_WIDTH  = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_wdata,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   localparam int IW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
   localparam int CW = $clog2(MAX_HITS + 1);

   cmd_type       cmd;
   stat_type      stat;
   logic [IW-1:0] addr_left, addr_right, scan_idx;
   logic [CW-1:0] left_cnt, right_cnt;

   csghc_ctrl #(
      .MAX_HITS (MAX_HITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_type   (req_item.req_type),
      .left_cnt   (left_cnt),
      .right_cnt  (right_cnt),
      .stat       (stat),
      .cmd        (cmd),
      .addr_left  (addr_left),
      .addr_right (addr_right),
      .scan_idx   (scan_idx)
   );

   csghc_dpath #(
      .MAX_HITS (MAX_HITS),
      .T_WIDTH  (T_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .hit_t      (req_item.hit_t),
      .cmd        (cmd),
      .addr_left  (addr_left),
      .addr_right (addr_right),
      .scan_idx   (scan_idx),
      .left_cnt   (left_cnt),
      .right_cnt  (right_cnt),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (left_cnt <= CW'(MAX_HITS)) && (right_cnt <= CW'(MAX_HITS)))
      else $error("hit count beyond capacity");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.rsp_free)
      else $error("result emitted over a pending item");

   a_keep_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.keep_wr |-> !cmd.cmp_v)
      else $error("classify written with compare in flight");

   a_nohit_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.no_hit) |-> (rsp_item.last_out && rsp_item.out_t == 0))
      else $error("no-hit item not final or not zero");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && stat.emit_last) |=> (req_ready && !cmd.scan_v))
      else $error("block not idle after last result");

endmodule

// ===== verif/csg_ray_hit_checker.sv =====
`timescale 1ns / 1ps

module csg_ray_hit_checker import csghc_pkg::*; #(
   parameter int MAX_HITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_wdata,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_item_type rsp_item,
   output int           fail_count,
   output int           pending_count
);

   logic [1:0]         op_sel;
   logic signed [31:0] left_list  [MAX_HITS];
   logic signed [31:0] right_list [MAX_HITS];
   int                 left_n;
   int                 right_n;
   logic               dropped;
   int                 misses;
   rsp_item_type       ray_results [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      misses        = 0;
      op_sel        = OP_RESET;
      left_n        = 0;
      right_n       = 0;
      dropped       = 1'b0;
   end

   // odd count of hits in the chosen list at or below v
   function automatic logic is_inside(logic right_side, logic signed [31:0] v);
      int n;
      n = 0;
      if (right_side) begin
         for (int i = 0; i < right_n; i++)
            if (right_list[i] <= v) n++;
      end else begin
         for (int i = 0; i < left_n; i++)
            if (left_list[i] <= v) n++;
      end
      return n[0];
   endfunction

   task automatic store_hit(logic right_side, logic signed [31:0] v);
      if (right_side) begin
         if (right_n < MAX_HITS) begin
            right_list[right_n] = v;
            right_n++;
         end else begin
            dropped = 1'b1;
         end
      end else begin
         if (left_n < MAX_HITS) begin
            left_list[left_n] = v;
            left_n++;
         end else begin
            dropped = 1'b1;
         end
      end
   endtask

   task automatic combine_ray();
      rsp_item_type kept [$];
      rsp_item_type r;
      logic [1:0]   mode;
      logic         keep;
      int           pos;
      mode = (op_sel == OP_MINUS || op_sel == OP_INTERSECT) ? op_sel : OP_UNION;
      for (int i = 0; i < left_n + right_n; i++) begin
         r = '0;
         if (i < left_n) begin
            r.out_t = left_list[i];
            keep = is_inside(1'b1, left_list[i]);
            if (mode != OP_INTERSECT) keep = !keep;
         end else begin
            r.out_t      = right_list[i - left_n];
            r.from_right = 1'b1;
            keep = is_inside(1'b0, right_list[i - left_n]);
            if (mode == OP_UNION) keep = !keep;
         end
         if (keep) begin
            // insert after every kept hit at or below, so ties keep left hits first, each side in arrival order
            pos = kept.size();
            while (pos > 0 && $signed(kept[pos-1].out_t) > $signed(r.out_t)) pos--;
            kept.insert(pos, r);
         end
      end
      if (kept.size() == 0) begin
         r = '0;
         r.no_hit = 1'b1;
         kept = {r};
      end
      foreach (kept[k]) begin
         kept[k].overflowed = dropped;
         kept[k].last_out   = (k == kept.size() - 1);
         ray_results = {ray_results, kept[k]};
      end
      left_n  = 0;
      right_n = 0;
      dropped = 1'b0;
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         misses++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      rsp_item_type want;
      if (reset) begin
         op_sel  = OP_RESET;
         left_n  = 0;
         right_n = 0;
         dropped = 1'b0;
         ray_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (ray_results.size() == 0) begin
               $error("result item with nothing expected: out_t %0h", rsp_item.out_t);
               misses++;
            end else begin
               want = ray_results.pop_front();
               check_field("out_t", want.out_t, rsp_item.out_t);
               check_field("from_right", want.from_right, rsp_item.from_right);
               check_field("no_hit", want.no_hit, rsp_item.no_hit);
               check_field("overflowed", want.overflowed, rsp_item.overflowed);
               check_field("last_out", want.last_out, rsp_item.last_out);
            end
         end
         if (csr_we) op_sel = csr_wdata;
         if (req_valid && req_ready) begin
            case (req_item.req_type)
               REQ_LEFT:  store_hit(1'b0, req_item.hit_t);
               REQ_RIGHT: store_hit(1'b1, req_item.hit_t);
               REQ_END:   combine_ray();
               default:   ;
            endcase
         end
      end
      fail_count    <= misses;
      pending_count <= ray_results.size();
   end

endmodule

// ===== verif/tb_csg_ray_hit_combiner.sv =====
`timescale 1ns / 1ps

module tb_csg_ray_hit_combiner;
   import csghc_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 110;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int IDLE_SETTLE  = 8;
   localparam int END_SETTLE   = 200;

   logic         clock;
   logic         reset;
   logic         csr_we;
   logic [1:0]   csr_wdata;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_item;
   int           fail_count;
   int           pending_count;
   int           hits_sent;
   logic         sender_quiet;

   csg_ray_hit_combiner dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   csg_ray_hit_checker score (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_item      (rsp_item),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 4);
      if (r < 90) return $urandom_range(5, 10);
      return $urandom_range(15, 18);
   endfunction

   // hold valid and payload until the item is taken
   task automatic send_item(logic [1:0] kind, logic signed [31:0] val);
      int gap;
      gap = sender_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item  <= {kind, val};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (kind != REQ_UNUSED) hits_sent++;
   endtask

   task automatic settle_out(int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_op(logic [1:0] op);
      settle_out(IDLE_SETTLE);
      csr_wdata <= op;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic run_ray(int nl, int nr);
      logic signed [31:0] lq [$];
      logic signed [31:0] rq [$];
      logic signed [31:0] v;
      int                 style;
      style = $urandom_range(0, 9);
      for (int s = 0; s < 2; s++) begin
         v = $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
         for (int i = 0; i < (s ? nr : nl); i++) begin
            if (style < 6) v = v + $urandom_range(1, 32'h30000);
            else if (style < 8) v = ($signed($urandom_range(0, 4)) - 2) <<< 16;
            else v = $urandom;
            if (s != 0) rq = {rq, v};
            else lq = {lq, v};
         end
      end
      while (lq.size() + rq.size() > 0) begin
         if ($urandom_range(0, 19) == 0) send_item(REQ_UNUSED, $urandom);
         if (rq.size() == 0 || (lq.size() > 0 && $urandom_range(0, 1) == 0))
            send_item(REQ_LEFT, lq.pop_front());
         else
            send_item(REQ_RIGHT, rq.pop_front());
      end
      send_item(REQ_END, $urandom);
   endtask

   initial begin : rsp_side
      int n;
      rsp_ready = 1'b0;
      forever begin
         if ($urandom_range(0, 7) == 0) n = $urandom_range(40, 150);
         else n = $urandom_range(1, 6);
         rsp_ready <= 1'b1;
         repeat (n) @(posedge clock);
         n = pick_gap();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      int phase;
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_wdata    = OP_RESET;
      req_valid    = 1'b0;
      req_item     = '0;
      sender_quiet = 1'b0;
      hits_sent    = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty ray under the reset operator
      send_item(REQ_END, 32'sh7fffffff);
      // field extremes, equal left and right values
      send_item(REQ_LEFT, 32'sh80000000);
      send_item(REQ_LEFT, 32'sh00010000);
      send_item(REQ_RIGHT, 32'sh00010000);
      send_item(REQ_RIGHT, 32'sh7fffffff);
      send_item(REQ_END, 32'sh0);
      // unsorted list and an unused request
      write_op(OP_UNION);
      send_item(REQ_LEFT, 32'sh00030000);
      send_item(REQ_LEFT, 32'sh00010000);
      send_item(REQ_RIGHT, 32'sh00020000);
      send_item(REQ_UNUSED, 32'shffffffff);
      send_item(REQ_END, 32'sh55555555);
      write_op(OP_INTERSECT);
      send_item(REQ_LEFT, -32'sh00010000);
      send_item(REQ_LEFT, 32'sh00040000);
      send_item(REQ_RIGHT, 32'sh0);
      send_item(REQ_RIGHT, 32'sh00040000);
      send_item(REQ_END, 32'shaaaaaaaa);

      hits_sent = 0;
      phase = 0;
      while (hits_sent < RANDOM_ITEMS) begin
         write_op(phase < 4 ? phase[1:0] : 2'($urandom_range(0, 3)));
         sender_quiet = ($urandom_range(0, 4) == 0);
         // a left list one hit over capacity on the second phase
         run_ray(phase == 1 ? 17 : pick_count(), pick_count());
         repeat ($urandom_range(0, 2)) run_ray(pick_count(), pick_count());
         phase++;
      end
      sender_quiet = 1'b0;
      settle_out(END_SETTLE);
      if (fail_count == 0 && pending_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/csghc_pkg.sv
hw/rtl/csghc_dpath.sv
hw/rtl/csghc_ctrl.sv
hw/rtl/csg_ray_hit_combiner.sv
verif/csg_ray_hit_checker.sv
verif/tb_csg_ray_hit_combiner.sv
